// ===== hw/rtl/sdsad_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsad_pkg
// shared types and constants for the stereo sad disparity block
// ----------------------------------------------------------------------------
package sdsad_pkg;

    localparam int POS_W  = 10;
    localparam int RING_W = 5;
    localparam int DISP_W = 8;
    localparam int HALF_W = 5;

    localparam logic CFG_SEARCH_RANGE = 1'b0;
    localparam logic CFG_HALF_BLOCK   = 1'b1;

    localparam logic [6:0] SEARCH_RANGE_RESET = 7'd32;
    localparam logic [3:0] HALF_BLOCK_RESET   = 4'd4;

    typedef struct packed {
        logic [7:0]        left_pixel;
        logic [7:0]        right_pixel;
        logic [POS_W-1:0]  wr_col;
        logic [RING_W-1:0] wr_ring;
        logic [POS_W-1:0]  col_base;
        logic [RING_W-1:0] ring_start;
        logic [7:0]        res_row;
        logic [DISP_W-1:0] disp;
        logic [HALF_W-1:0] half;
        logic              produce;
        logic              last;
    } job_t;

endpackage

// ===== hw/rtl/sdsad_front.sv =====
// ----------------------------------------------------------------------------
// sdsad_front
// accepts pixel items, tracks raster position and classifies each item
// ----------------------------------------------------------------------------
module sdsad_front #(
    parameter int IMAGE_WIDTH    = 256,
    parameter int IMAGE_HEIGHT   = 256,
    parameter int MAX_HALF_BLOCK = 8,
    parameter int SEARCH_LIMIT   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        left_pixel,
    input  logic [7:0]        right_pixel,
    input  logic [6:0]        search_range,
    input  logic [3:0]        half_block,
    input  logic              q_full,
    output logic              q_push,
    output sdsad_pkg::job_t   q_job
);

    localparam int CW  = $clog2(IMAGE_WIDTH);
    localparam int RW  = $clog2(IMAGE_HEIGHT);
    localparam int RR  = 2 * MAX_HALF_BLOCK;
    localparam int RGW = $clog2(RR);
    localparam int TW  = $clog2(IMAGE_WIDTH + IMAGE_HEIGHT + 2*SEARCH_LIMIT
                                + 4*MAX_HALF_BLOCK + 4) + 1;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [RGW-1:0] ring_reg, ring_next;
    logic [TW-1:0]  rr, cc, dd, hh, ring_t, ring_s;
    logic           due;

    always_comb
    begin
        dd = TW'(search_range);
        if (dd == TW'(0))
            dd = TW'(1);
        else if (dd > TW'(SEARCH_LIMIT))
            dd = TW'(SEARCH_LIMIT);
        hh = TW'(half_block);
        if (hh == TW'(0))
            hh = TW'(1);
        else if (hh > TW'(MAX_HALF_BLOCK))
            hh = TW'(MAX_HALF_BLOCK);
        rr     = TW'(row_reg);
        cc     = TW'(col_reg);
        ring_t = TW'(ring_reg);
        due = (rr + TW'(1) >= TW'(2) * hh) && (rr + TW'(2) <= TW'(IMAGE_HEIGHT))
            && (cc + TW'(2) >= TW'(2) * hh + dd) && (cc + TW'(3) <= TW'(IMAGE_WIDTH));
        if (ring_t + TW'(1) < TW'(2) * hh)
            ring_s = ring_t + TW'(1) + TW'(RR) - TW'(2) * hh;
        else
            ring_s = ring_t + TW'(1) - TW'(2) * hh;
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_job.left_pixel  = left_pixel;
        q_job.right_pixel = right_pixel;
        q_job.wr_col      = sdsad_pkg::POS_W'(col_reg);
        q_job.wr_ring     = sdsad_pkg::RING_W'(ring_reg);
        q_job.col_base    = sdsad_pkg::POS_W'(cc + TW'(2) - TW'(2) * hh - dd);
        q_job.ring_start  = sdsad_pkg::RING_W'(ring_s);
        q_job.res_row     = 8'(rr + TW'(1) - TW'(2) * hh);
        q_job.disp        = sdsad_pkg::DISP_W'(dd);
        q_job.half        = sdsad_pkg::HALF_W'(hh);
        q_job.produce     = due;
        q_job.last        = (rr + TW'(2) == TW'(IMAGE_HEIGHT))
                         && (cc + TW'(3) == TW'(IMAGE_WIDTH));
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ring_next = ring_reg;
        if (TW'(col_reg) + TW'(1) >= TW'(IMAGE_WIDTH))
        begin
            col_next = '0;
            if (TW'(row_reg) + TW'(1) >= TW'(IMAGE_HEIGHT))
            begin
                row_next  = '0;
                ring_next = '0;
            end
            else
            begin
                row_next  = row_reg + RW'(1);
                ring_next = (TW'(ring_reg) == TW'(RR - 1)) ? '0 : ring_reg + RGW'(1);
            end
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ring_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ring_reg <= ring_next;
        end
    end

endmodule

// ===== hw/rtl/sdsad_queue.sv =====
// ----------------------------------------------------------------------------
// sdsad_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module sdsad_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sdsad_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output sdsad_pkg::job_t pop_job
);

    sdsad_pkg::job_t entry_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== hw/rtl/sdsad_back.sv =====
// ----------------------------------------------------------------------------
// sdsad_back
// line stores and sequential window search over all offsets
// ----------------------------------------------------------------------------
module sdsad_back #(
    parameter int IMAGE_WIDTH    = 256,
    parameter int MAX_HALF_BLOCK = 8,
    parameter int SEARCH_LIMIT   = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  sdsad_pkg::job_t q_job,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [5:0]      disparity,
    output logic [7:0]      out_row,
    output logic [7:0]      out_col,
    output logic            frame_last
);

    localparam int RR    = 2 * MAX_HALF_BLOCK;
    localparam int RGW   = $clog2(RR);
    localparam int DEPTH = RR * IMAGE_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(SEARCH_LIMIT + 1);
    localparam int HW    = $clog2(2 * MAX_HALF_BLOCK + 1);
    localparam int SW    = $clog2(4 * MAX_HALF_BLOCK * MAX_HALF_BLOCK * 255 + 2);
    localparam int XW    = AW + 2;

    typedef enum logic [2:0] {S_IDLE, S_WRITE, S_RUN, S_WAIT, S_EMIT} state_t;

    logic [7:0]      left_mem  [DEPTH];
    logic [7:0]      right_mem [DEPTH];

    state_t          state_reg;
    sdsad_pkg::job_t job_reg;
    logic [DW-1:0]   off_reg;
    logic [HW-1:0]   a_reg, b_reg;
    logic [RGW-1:0]  ring_reg;
    logic [SW-1:0]   sad_reg, best_sad_reg;
    logic [DW-1:0]   best_reg;
    logic            rd_v_reg, rd_endoff_reg, rd_end_reg;
    logic [DW-1:0]   rd_off_reg;
    logic [7:0]      lq_reg, rq_reg;
    logic            out_valid_reg, frame_last_reg;
    logic [5:0]      disparity_reg;
    logic [7:0]      out_row_reg, out_col_reg;

    logic            wr_en, last_a, last_b, last_off;
    logic [AW-1:0]   wr_addr, rdl_addr, rdr_addr;
    logic [XW-1:0]   row_off;
    logic [HW-1:0]   win_last;
    logic [7:0]      diff;
    logic [SW-1:0]   sum;

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign wr_en    = (state_reg == S_WRITE);
    assign win_last = HW'(2 * job_reg.half - 1);
    assign last_a   = (a_reg == win_last);
    assign last_b   = (b_reg == win_last);
    assign last_off = (DW'(off_reg) + DW'(1) == DW'(job_reg.disp));
    assign row_off  = XW'(ring_reg) * XW'(IMAGE_WIDTH);
    assign wr_addr  = AW'(XW'(job_reg.wr_ring) * XW'(IMAGE_WIDTH) + XW'(job_reg.wr_col));
    assign rdl_addr = AW'(row_off + XW'(job_reg.col_base) + XW'(b_reg));
    assign rdr_addr = AW'(row_off + XW'(job_reg.col_base) + XW'(b_reg) + XW'(off_reg));
    assign diff     = (lq_reg > rq_reg) ? lq_reg - rq_reg : rq_reg - lq_reg;
    assign sum      = sad_reg + SW'(diff);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= job_reg.left_pixel;
            right_mem[wr_addr] <= job_reg.right_pixel;
        end
        lq_reg <= left_mem[rdl_addr];
        rq_reg <= right_mem[rdr_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (state_reg == S_RUN);
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            // accumulate the registered read data
            if (rd_v_reg)
            begin
                if (rd_endoff_reg)
                begin
                    if (sum < best_sad_reg)
                    begin
                        best_sad_reg <= sum;
                        best_reg     <= rd_off_reg;
                    end
                    sad_reg <= '0;
                end
                else
                begin
                    sad_reg <= sum;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= q_job;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    off_reg      <= '0;
                    a_reg        <= '0;
                    b_reg        <= '0;
                    ring_reg     <= RGW'(job_reg.ring_start);
                    sad_reg      <= '0;
                    best_sad_reg <= '1;
                    best_reg     <= '0;
                    state_reg    <= job_reg.produce ? S_RUN : S_IDLE;
                end
                S_RUN:
                begin
                    rd_endoff_reg <= last_a && last_b;
                    rd_end_reg    <= last_a && last_b && last_off;
                    rd_off_reg    <= off_reg;
                    if (!last_b)
                    begin
                        b_reg <= b_reg + HW'(1);
                    end
                    else
                    begin
                        b_reg <= '0;
                        if (last_a)
                        begin
                            a_reg    <= '0;
                            ring_reg <= RGW'(job_reg.ring_start);
                            off_reg  <= off_reg + DW'(1);
                            if (last_off)
                                state_reg <= S_WAIT;
                        end
                        else
                        begin
                            a_reg    <= a_reg + HW'(1);
                            ring_reg <= (32'(ring_reg) == RR - 1) ? '0 : ring_reg + RGW'(1);
                        end
                    end
                end
                S_WAIT:
                begin
                    if (rd_v_reg && rd_end_reg)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        disparity_reg  <= 6'(best_reg);
                        out_row_reg    <= job_reg.res_row;
                        out_col_reg    <= 8'(job_reg.col_base);
                        frame_last_reg <= job_reg.last;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign disparity  = disparity_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== hw/rtl/stereo_sad_disparity.sv =====
// ----------------------------------------------------------------------------
// stereo_sad_disparity
// stereo block matching by sum of absolute differences
//
//   channel   signals                                     direction
//   in        in_valid in_stall left_pixel right_pixel    item in
//   out       out_valid out_stall disparity out_row
//             out_col frame_last                          item out
//   cfg       psel penable pwrite paddr pwdata prdata
//             pready                                      register access
//
// an item without a result only passes through the write state in the back end; one
// with a result then runs the window search, one read of each line store per cycle
// a finished result waits in the output register while out_stall is high
// a two-entry queue lets the front keep taking items while the back works
// reset clears position counters, queue pointers, state and valid flags and loads the
// config defaults; line stores and data registers are not cleared
module stereo_sad_disparity #(
    parameter int IMAGE_WIDTH    = 256,
    parameter int IMAGE_HEIGHT   = 256,
    parameter int MAX_HALF_BLOCK = 8,
    parameter int SEARCH_LIMIT   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  left_pixel,
    input  logic [7:0]  right_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  disparity,
    output logic [7:0]  out_row,
    output logic [7:0]  out_col,
    output logic        frame_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0]      search_range_reg;
    logic [3:0]      half_block_reg;
    logic            q_full, q_empty, q_push, q_pop;
    sdsad_pkg::job_t push_job, pop_job;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_range_reg <= sdsad_pkg::SEARCH_RANGE_RESET;
            half_block_reg   <= sdsad_pkg::HALF_BLOCK_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == sdsad_pkg::CFG_SEARCH_RANGE)
                search_range_reg <= pwdata[6:0];
            else
                half_block_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == sdsad_pkg::CFG_HALF_BLOCK)
            prdata = {28'd0, half_block_reg};
        else
            prdata = {25'd0, search_range_reg};
    end

    sdsad_front #(
        .IMAGE_WIDTH    (IMAGE_WIDTH),
        .IMAGE_HEIGHT   (IMAGE_HEIGHT),
        .MAX_HALF_BLOCK (MAX_HALF_BLOCK),
        .SEARCH_LIMIT   (SEARCH_LIMIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .left_pixel   (left_pixel),
        .right_pixel  (right_pixel),
        .search_range (search_range_reg),
        .half_block   (half_block_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    sdsad_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    sdsad_back #(
        .IMAGE_WIDTH    (IMAGE_WIDTH),
        .MAX_HALF_BLOCK (MAX_HALF_BLOCK),
        .SEARCH_LIMIT   (SEARCH_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (pop_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .disparity  (disparity),
        .out_row    (out_row),
        .out_col    (out_col),
        .frame_last (frame_last)
    );

endmodule
